// ----- src/bms_pkg.sv -----
// ---------------------------------------------------------------------------
// bms_pkg
// Shared types and constants for the balance mode supervisor: request and
// result payloads, configuration set, check flags, mode and register codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

    // motion modes
    typedef enum logic [1:0] {
        MODE_DISARMED  = 2'd0,
        MODE_BALANCING = 2'd1,
        MODE_FALLEN    = 2'd2,
        MODE_FAULT     = 2'd3
    } mode_t;

    // request commands
    typedef enum logic {
        CMD_STEP = 1'b0,
        CMD_SET  = 1'b1
    } cmd_t;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_IMU_FALLEN   = 3'd0,
        CFG_IMU_FATAL    = 3'd1,
        CFG_MOTOR_FALLEN = 3'd2,
        CFG_MOTOR_FATAL  = 3'd3,
        CFG_TILT_KILL    = 3'd4,
        CFG_DUMP_SECS    = 3'd5
    } cfg_idx_t;

    // register reset values
    localparam logic [15:0]        IMU_FALLEN_RST   = 16'd100;
    localparam logic [15:0]        IMU_FATAL_RST    = 16'd500;
    localparam logic [15:0]        MOTOR_FALLEN_RST = 16'd100;
    localparam logic [15:0]        MOTOR_FATAL_RST  = 16'd500;
    localparam logic signed [15:0] TILT_KILL_RST    = 16'sd2867;
    localparam logic [15:0]        DUMP_SECS_RST    = 16'd0;

    // dump length used when dump_secs is zero
    localparam logic [15:0] DUMP_DEFAULT = 16'd30;

    // largest absolute tilt in Q3.12
    localparam logic [15:0] TILT_ABS_MAX = 16'h7fff;

    typedef struct packed {
        logic              cmd;
        logic [1:0]        set_mode;
        logic [31:0]       now_time;
        logic [31:0]       imu_ok_time;
        logic [31:0]       imu_irq_time;
        logic [31:0]       motor_ok_time;
        logic              fused_ok;
        logic signed [15:0] tilt;
        logic              accel_tilt_valid;
        logic signed [15:0] accel_tilt;
    } bms_in_t;

    typedef struct packed {
        logic        mode_diff;
        logic [1:0]  mode_after;
        logic        motor_off;
        logic        reset_controller;
        logic        dump_request;
        logic [15:0] dump_length;
        logic        drive_allowed;
    } bms_out_t;

    typedef struct packed {
        logic [15:0]        imu_fallen_ms;
        logic [15:0]        imu_fatal_ms;
        logic [15:0]        motor_fallen_ms;
        logic [15:0]        motor_fatal_ms;
        logic signed [15:0] tilt_kill;
        logic [15:0]        dump_secs;
    } bms_cfg_t;

    // outcome of the tilt and link checks for one request
    typedef struct packed {
        logic kill_hit;
        logic imu_fallen;
        logic motor_fallen;
        logic imu_fatal;
        logic irq_fatal;
        logic motor_fatal;
    } bms_flags_t;

endpackage

`default_nettype wire

// ----- src/bms_monitor.sv -----
// ---------------------------------------------------------------------------
// bms_monitor
// Tilt kill and link timeout checks for one request. Ages are taken modulo
// 2^TIME_WIDTH; a time of zero means never seen and never times out.
// ---------------------------------------------------------------------------
`default_nettype none

module bms_monitor #(
    parameter int TIME_WIDTH = 32
) (
    input  bms_pkg::bms_in_t    req,
    input  bms_pkg::bms_cfg_t   cfg,
    output bms_pkg::bms_flags_t flags
);
    import bms_pkg::*;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] imu_t;
    logic [TIME_WIDTH-1:0] irq_t;
    logic [TIME_WIDTH-1:0] mot_t;
    logic [15:0]           tilt_abs;
    logic [15:0]           accel_abs;
    logic                  kill_on;
    logic                  kill_hit;

    // seen and older than the limit
    function automatic logic timed_out(
        input logic [TIME_WIDTH-1:0] now_v,
        input logic [TIME_WIDTH-1:0] then_v,
        input logic [15:0]           limit
    );
        logic [TIME_WIDTH-1:0] age;
        begin
            age = now_v - then_v;
            timed_out = (then_v != '0) && (age > TIME_WIDTH'(limit));
        end
    endfunction

    // absolute value with the most negative code saturated
    function automatic logic [15:0] abs_sat(input logic signed [15:0] v);
        logic [15:0] neg;
        begin
            neg = 16'(-v);
            if (!v[15])
            begin
                abs_sat = 16'(v);
            end
            else if (v == 16'sh8000)
            begin
                abs_sat = TILT_ABS_MAX;
            end
            else
            begin
                abs_sat = neg;
            end
        end
    endfunction

    // times fitted to the counter width
    assign now_t = TIME_WIDTH'(req.now_time);
    assign imu_t = TIME_WIDTH'(req.imu_ok_time);
    assign irq_t = TIME_WIDTH'(req.imu_irq_time);
    assign mot_t = TIME_WIDTH'(req.motor_ok_time);

    // tilt kill, fused estimate first, accelerometer as fallback
    assign tilt_abs  = abs_sat(req.tilt);
    assign accel_abs = abs_sat(req.accel_tilt);
    assign kill_on   = !cfg.tilt_kill[15] && (cfg.tilt_kill != '0);

    always_comb
    begin
        kill_hit = 1'b0;
        if (kill_on)
        begin
            if (req.fused_ok)
            begin
                kill_hit = tilt_abs > 16'(cfg.tilt_kill);
            end
            else if (req.accel_tilt_valid)
            begin
                kill_hit = accel_abs > 16'(cfg.tilt_kill);
            end
        end
    end

    assign flags.kill_hit = kill_hit;

    // link timeouts
    assign flags.imu_fallen   = timed_out(now_t, imu_t, cfg.imu_fallen_ms);
    assign flags.motor_fallen = timed_out(now_t, mot_t, cfg.motor_fallen_ms);
    assign flags.imu_fatal    = timed_out(now_t, imu_t, cfg.imu_fatal_ms);
    assign flags.irq_fatal    = timed_out(now_t, irq_t, cfg.imu_fatal_ms);
    assign flags.motor_fatal  = timed_out(now_t, mot_t, cfg.motor_fatal_ms);

endmodule

`default_nettype wire

// ----- src/bms_mode.sv -----
// ---------------------------------------------------------------------------
// bms_mode
// Mode transition logic: applies a set command or a supervisor step to the
// current mode and forms the result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module bms_mode (
    input  bms_pkg::bms_in_t    req,
    input  bms_pkg::bms_flags_t flags,
    input  logic [15:0]         dump_secs,
    input  bms_pkg::mode_t      mode,
    output bms_pkg::mode_t      mode_next,
    output bms_pkg::bms_out_t   res
);
    import bms_pkg::*;

    logic  fall;
    logic  fatal;
    logic  moved;
    mode_t mid_mode;

    // fall check only while balancing
    assign fall = (mode == MODE_BALANCING) &&
                  (flags.kill_hit || flags.imu_fallen || flags.motor_fallen);
    assign fatal = flags.imu_fatal || flags.irq_fatal || flags.motor_fatal;
    assign mid_mode = fall ? MODE_FALLEN : mode;

    // next mode and whether a step moved it
    always_comb
    begin
        mode_next = mode;
        moved     = 1'b0;
        case (cmd_t'(req.cmd))
            CMD_SET:
            begin
                mode_next = mode_t'(req.set_mode);
            end
            CMD_STEP:
            begin
                mode_next = mid_mode;
                moved     = fall;
                if (fatal && (mid_mode != MODE_DISARMED) && (mid_mode != MODE_FAULT))
                begin
                    mode_next = MODE_FAULT;
                    moved     = 1'b1;
                end
            end
            default:
            begin
                mode_next = mode;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res.mode_diff        = mode_next != mode;
        res.mode_after       = mode_next;
        res.motor_off        = moved;
        res.reset_controller = moved;
        res.dump_request     = (req.cmd == CMD_STEP) && fall;
        res.dump_length      = (dump_secs == '0) ? DUMP_DEFAULT : dump_secs;
        res.drive_allowed    = mode_next == MODE_BALANCING;
    end

endmodule

`default_nettype wire

// ----- src/balance_mode_supervisor_top.sv -----
// ---------------------------------------------------------------------------
// balance_mode_supervisor_top
// Motion mode supervisor for a balancing robot with request and result
// channels and a plain register write port.
// ---------------------------------------------------------------------------
// Every request gives exactly one result. A request is captured in an input
// register, the checks and the mode update are combinational, and the result
// is held in an output register. One request per cycle is sustained while
// results are taken. The rate is set by the loop through the mode register:
// each request sees the mode left by the one before. A stalled result stalls
// the input register, and the request port then holds ready low. Register
// writes are taken at once, with no read-back; writes to indexes past the
// last register are ignored. After reset the mode is disarmed and the
// registers hold 100, 500, 100, 500 ms, tilt kill 2867 (Q3.12) and dump
// length 0 (30 s).
// ---------------------------------------------------------------------------
`default_nettype none

module balance_mode_supervisor_top #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  bms_pkg::bms_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output bms_pkg::bms_out_t                     out_data,
    input  logic                                  cfg_write,
    input  logic [bms_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [bms_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import bms_pkg::*;

    logic       in_valid_reg;
    bms_in_t    in_data_reg;
    logic       out_valid_reg;
    bms_out_t   out_data_reg;
    mode_t      mode_reg;
    mode_t      mode_next;
    bms_cfg_t   cfg_reg;
    bms_flags_t flags;
    bms_out_t   res;
    logic       advance;

    // pipeline flow
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.imu_fallen_ms   <= IMU_FALLEN_RST;
            cfg_reg.imu_fatal_ms    <= IMU_FATAL_RST;
            cfg_reg.motor_fallen_ms <= MOTOR_FALLEN_RST;
            cfg_reg.motor_fatal_ms  <= MOTOR_FATAL_RST;
            cfg_reg.tilt_kill       <= TILT_KILL_RST;
            cfg_reg.dump_secs       <= DUMP_SECS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMU_FALLEN:   cfg_reg.imu_fallen_ms   <= cfg_data;
                CFG_IMU_FATAL:    cfg_reg.imu_fatal_ms    <= cfg_data;
                CFG_MOTOR_FALLEN: cfg_reg.motor_fallen_ms <= cfg_data;
                CFG_MOTOR_FATAL:  cfg_reg.motor_fatal_ms  <= cfg_data;
                CFG_TILT_KILL:    cfg_reg.tilt_kill       <= signed'(cfg_data);
                CFG_DUMP_SECS:    cfg_reg.dump_secs       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // checks and mode update
    bms_monitor #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_monitor (
        .req   (in_data_reg),
        .cfg   (cfg_reg),
        .flags (flags)
    );

    bms_mode u_mode (
        .req          (in_data_reg),
        .flags        (flags),
        .dump_secs    (cfg_reg.dump_secs),
        .mode         (mode_reg),
        .mode_next    (mode_next),
        .res          (res)
    );

    // mode and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DISARMED;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    // checks on the supervisor's own logic
    a_mode_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_data_reg.mode_after == mode_reg))
        else $error("mode register differs from the last result mode");

    a_dump_disables: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.dump_request |-> out_data_reg.motor_off)
        else $error("dump requested without disabling the motors");

    a_move_changes_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.motor_off |-> out_data_reg.mode_diff)
        else $error("motors disabled without a mode change");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_valid_reg |-> !in_ready)
        else $error("request taken while the pipeline is stalled");

endmodule

`default_nettype wire

// ----- test/bms_mode_checker.sv -----
// ---------------------------------------------------------------------------
// bms_mode_checker
// Watches the request, result and register write ports of the balance mode
// supervisor. Keeps its own copy of the mode and register set, predicts the
// result of every accepted request and compares each accepted result with
// the oldest prediction still waiting.
// ---------------------------------------------------------------------------

module bms_mode_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  bms_pkg::bms_in_t   in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  bms_pkg::bms_out_t  out_data,
    input  logic               cfg_write,
    input  logic [bms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bms_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 results_checked,
    output int                 dumps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    bms_cfg_t regs_now;
    mode_t    mode_now;
    bms_out_t mode_reports_due[$];

    // magnitude of a Q3.12 tilt, with the most negative value clipped
    function automatic int tilt_mag(input logic signed [15:0] v);
        int x;
        x = int'($signed(v));
        if (x < 0)
            x = -x;
        if (x > 32767)
            x = 32767;
        return x;
    endfunction

    // a link is stale when it was seen and its wrapped age is over the limit
    function automatic logic link_stale(input logic [31:0] now_ms,
                                        input logic [31:0] seen_ms,
                                        input logic [15:0] limit_ms);
        logic [31:0] age;
        age = now_ms - seen_ms;
        return (seen_ms != 32'd0) && (age > {16'd0, limit_ms});
    endfunction

    // mode update and result for one request
    function automatic bms_out_t predict_mode_step(input bms_in_t r, input mode_t cur,
                                                   input bms_cfg_t c);
        bms_out_t o;
        mode_t    nxt;
        logic     moved;
        logic     dump;
        logic     kill;
        int       kill_lim;
        nxt   = cur;
        moved = 1'b0;
        dump  = 1'b0;
        kill  = 1'b0;
        if (r.cmd == CMD_SET)
        begin
            nxt = mode_t'(r.set_mode);
        end
        else
        begin
            // balancing: tilt kill or short link silence means a fall
            if (cur == MODE_BALANCING)
            begin
                kill_lim = int'($signed(c.tilt_kill));
                if (kill_lim > 0)
                begin
                    if (r.fused_ok)
                        kill = tilt_mag(r.tilt) > kill_lim;
                    else if (r.accel_tilt_valid)
                        kill = tilt_mag(r.accel_tilt) > kill_lim;
                end
                if (kill || link_stale(r.now_time, r.imu_ok_time, c.imu_fallen_ms)
                         || link_stale(r.now_time, r.motor_ok_time, c.motor_fallen_ms))
                begin
                    nxt   = MODE_FALLEN;
                    moved = 1'b1;
                    dump  = 1'b1;
                end
            end
            // long silence forces fault, also straight after a fall
            if (nxt != MODE_DISARMED && nxt != MODE_FAULT)
            begin
                if (link_stale(r.now_time, r.imu_ok_time, c.imu_fatal_ms)
                    || link_stale(r.now_time, r.imu_irq_time, c.imu_fatal_ms)
                    || link_stale(r.now_time, r.motor_ok_time, c.motor_fatal_ms))
                begin
                    nxt   = MODE_FAULT;
                    moved = 1'b1;
                end
            end
        end
        o.mode_diff        = (nxt != cur);
        o.mode_after       = nxt;
        o.motor_off        = moved;
        o.reset_controller = moved;
        o.dump_request     = dump;
        o.dump_length      = (c.dump_secs == 16'd0) ? DUMP_DEFAULT : c.dump_secs;
        o.drive_allowed    = (nxt == MODE_BALANCING);
        return o;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare results, track register writes, predict accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        bms_out_t want;
        if (!rst_n)
        begin
            regs_now.imu_fallen_ms   = IMU_FALLEN_RST;
            regs_now.imu_fatal_ms    = IMU_FATAL_RST;
            regs_now.motor_fallen_ms = MOTOR_FALLEN_RST;
            regs_now.motor_fatal_ms  = MOTOR_FATAL_RST;
            regs_now.tilt_kill       = TILT_KILL_RST;
            regs_now.dump_secs       = DUMP_SECS_RST;
            mode_now = MODE_DISARMED;
            mode_reports_due.delete();
            fail_count      = 0;
            results_checked = 0;
            dumps_seen      = 0;
            pending         = 0;
        end
        else
        begin
            // result side
            if (out_valid && out_ready)
            begin
                if (mode_reports_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = mode_reports_due.pop_front();
                    report_field("mode_diff", want.mode_diff, out_data.mode_diff);
                    report_field("mode_after", want.mode_after, out_data.mode_after);
                    report_field("motor_off", want.motor_off, out_data.motor_off);
                    report_field("reset_controller", want.reset_controller,
                                 out_data.reset_controller);
                    report_field("dump_request", want.dump_request, out_data.dump_request);
                    report_field("dump_length", want.dump_length, out_data.dump_length);
                    report_field("drive_allowed", want.drive_allowed, out_data.drive_allowed);
                    results_checked++;
                    if (want.dump_request)
                        dumps_seen++;
                end
            end
            // register writes
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_IMU_FALLEN:   regs_now.imu_fallen_ms   = cfg_data;
                    CFG_IMU_FATAL:    regs_now.imu_fatal_ms    = cfg_data;
                    CFG_MOTOR_FALLEN: regs_now.motor_fallen_ms = cfg_data;
                    CFG_MOTOR_FATAL:  regs_now.motor_fatal_ms  = cfg_data;
                    CFG_TILT_KILL:    regs_now.tilt_kill       = cfg_data;
                    CFG_DUMP_SECS:    regs_now.dump_secs       = cfg_data;
                    default: ;
                endcase
            end
            // request side
            if (in_valid && in_ready)
            begin
                want = predict_mode_step(in_data, mode_now, regs_now);
                mode_now = mode_t'(want.mode_after);
                mode_reports_due.push_back(want);
            end
            pending = mode_reports_due.size();
        end
    end

endmodule

// ----- test/balance_mode_supervisor_top_tb.sv -----
// ---------------------------------------------------------------------------
// balance_mode_supervisor_top_tb
// Stimulus and verdict for the balance mode supervisor: a directed run over
// tilt kills, link timeouts, wrapped and never-seen times and every mode,
// then random mode sequences under several register settings, with random
// gaps on the request side and random stalls on the result side.
// ---------------------------------------------------------------------------

module balance_mode_supervisor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    bms_in_t in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    bms_out_t out_data;
    logic cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;
    logic steady;

    int fail_count;
    int pending;
    int results_checked;
    int dumps_seen;
    int sent;
    int settings_used;

    bms_cfg_t active_cfg;
    logic [31:0] clock_ms;

    balance_mode_supervisor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bms_mode_checker mode_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .dumps_seen      (dumps_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stalls
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 26);

    // run limit
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one request, with random gaps before it, and wait for acceptance
    task automatic send_req(input bms_in_t r);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    // hold off requests until every result is in
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // write all six registers while idle
    task automatic load_settings(input bms_cfg_t c);
        logic [15:0] vals [6];
        drain();
        vals[CFG_IMU_FALLEN]   = c.imu_fallen_ms;
        vals[CFG_IMU_FATAL]    = c.imu_fatal_ms;
        vals[CFG_MOTOR_FALLEN] = c.motor_fallen_ms;
        vals[CFG_MOTOR_FATAL]  = c.motor_fatal_ms;
        vals[CFG_TILT_KILL]    = c.tilt_kill;
        vals[CFG_DUMP_SECS]    = c.dump_secs;
        cfg_write <= 1'b1;
        for (int i = CFG_IMU_FALLEN; i <= CFG_DUMP_SECS; i++)
        begin
            cfg_index <= CFG_INDEX_WIDTH'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        active_cfg = c;
        settings_used++;
    endtask

    function automatic bms_in_t set_req(input mode_t m);
        bms_in_t r;
        r.cmd              = CMD_SET;
        r.set_mode         = m;
        r.now_time         = $urandom();
        r.imu_ok_time      = $urandom();
        r.imu_irq_time     = $urandom();
        r.motor_ok_time    = $urandom();
        r.fused_ok         = 1'($urandom_range(1));
        r.tilt             = 16'($urandom());
        r.accel_tilt_valid = 1'($urandom_range(1));
        r.accel_tilt       = 16'($urandom());
        return r;
    endfunction

    function automatic bms_in_t step_req(input logic [31:0] now_ms, input logic [31:0] imu_ms,
                                         input logic [31:0] irq_ms, input logic [31:0] mot_ms,
                                         input logic est_ok, input logic signed [15:0] tilt,
                                         input logic acc_ok, input logic signed [15:0] acc);
        bms_in_t r;
        r.cmd              = CMD_STEP;
        r.set_mode         = 2'($urandom_range(3));
        r.now_time         = now_ms;
        r.imu_ok_time      = imu_ms;
        r.imu_irq_time     = irq_ms;
        r.motor_ok_time    = mot_ms;
        r.fused_ok         = est_ok;
        r.tilt             = tilt;
        r.accel_tilt_valid = acc_ok;
        r.accel_tilt       = acc;
        return r;
    endfunction

    // link time: never seen, near a limit, fresh or anything
    function automatic logic [31:0] pick_time(input logic [31:0] now_ms,
                                              input logic [15:0] lim_a,
                                              input logic [15:0] lim_b);
        logic [15:0] lim;
        logic [31:0] age;
        int          roll;
        lim  = $urandom_range(1) ? lim_a : lim_b;
        roll = $urandom_range(99);
        if (roll < 8)
            return 32'd0;
        if (roll < 30)
            age = {16'd0, lim} + 32'($urandom_range(4)) - 32'd2;
        else if (roll < 85)
            age = 32'($urandom_range(0, lim));
        else
            age = $urandom();
        return now_ms - age;
    endfunction

    // tilt: extremes, near the kill limit, small or anything
    function automatic logic signed [15:0] pick_tilt();
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh8001;
                default: return 16'sh0000;
            endcase
        end
        if (roll < 45)
        begin
            v = int'($signed(active_cfg.tilt_kill)) + int'($urandom_range(4)) - 2;
            if ($urandom_range(1))
                v = -v;
            return 16'(v);
        end
        if (roll < 85)
            return 16'(int'($urandom_range(1000)) - 500);
        return 16'($urandom());
    endfunction

    // random request: mostly steps along a running clock, some mode sets
    function automatic bms_in_t random_req();
        bms_in_t r;
        if ($urandom_range(99) < 18)
        begin
            r = set_req(mode_t'($urandom_range(3)));
            if ($urandom_range(99) < 60)
                r.set_mode = MODE_BALANCING;
            return r;
        end
        if ($urandom_range(99) < 5)
            clock_ms = $urandom_range(1) ? $urandom() : 32'hffff_ffc0;
        else
            clock_ms = clock_ms + 32'($urandom_range(40));
        return step_req(clock_ms,
                        pick_time(clock_ms, active_cfg.imu_fallen_ms, active_cfg.imu_fatal_ms),
                        pick_time(clock_ms, active_cfg.imu_fatal_ms, active_cfg.imu_fatal_ms),
                        pick_time(clock_ms, active_cfg.motor_fallen_ms,
                                  active_cfg.motor_fatal_ms),
                        1'($urandom_range(1)), pick_tilt(), 1'($urandom_range(1)),
                        pick_tilt());
    endfunction

    // register settings for each random phase
    function automatic bms_cfg_t phase_settings(input int p);
        bms_cfg_t c;
        c.imu_fallen_ms   = 16'($urandom_range(400));
        c.imu_fatal_ms    = 16'($urandom_range(1000));
        c.motor_fallen_ms = 16'($urandom_range(400));
        c.motor_fatal_ms  = 16'($urandom_range(1000));
        c.tilt_kill       = 16'($urandom());
        c.dump_secs       = 16'($urandom());
        case (p)
            1:
            begin
                c = '0;
            end
            2:
            begin
                c = '1;
                c.tilt_kill = 16'sh7fff;
            end
            3:
            begin
                c.tilt_kill = 16'sh8000;
                c.dump_secs = 16'd1;
            end
            4:
            begin
                c.tilt_kill = 16'sh0001;
            end
            default: ;
        endcase
        return c;
    endfunction

    // directed run under the reset settings
    task automatic run_directed();
        logic [31:0] t;
        t = 32'h0001_0000;
        send_req(set_req(MODE_BALANCING));
        send_req(set_req(MODE_BALANCING));
        // fresh links, fused tilt level, accelerometer ignored
        send_req(step_req(t, t - 10, t - 5, t - 20, 1'b1, 16'sh0000, 1'b1, 16'sh7fff));
        // fused tilt just over the kill limit
        send_req(step_req(t, t, t, t, 1'b1, 16'sd2868, 1'b0, 16'sh0000));
        send_req(set_req(MODE_BALANCING));
        // tilt exactly at the limit, both signs
        send_req(step_req(t, t, t, t, 1'b1, 16'sd2867, 1'b0, 16'sh0000));
        send_req(step_req(t, t, t, t, 1'b1, -16'sd2867, 1'b0, 16'sh0000));
        // accelerometer fallback, most negative value clipped
        send_req(step_req(t, t, t, t, 1'b0, 16'sh0000, 1'b1, 16'sh8000));
        send_req(set_req(MODE_BALANCING));
        // no valid tilt source, then fused tilt at the most negative value
        send_req(step_req(t, t, t, t, 1'b0, 16'sh7fff, 1'b0, 16'sh8000));
        send_req(step_req(t, t, t, t, 1'b1, 16'sh8000, 1'b0, 16'sh0000));
        // imu silence at and past the fall limit
        send_req(set_req(MODE_BALANCING));
        send_req(step_req(t, t - 100, t, t, 1'b0, 16'sh0000, 1'b0, 16'sh0000));
        send_req(step_req(t, t - 101, t, t, 1'b0, 16'sh0000, 1'b0, 16'sh0000));
        // motor silence
        send_req(set_req(MODE_BALANCING));
        send_req(step_req(t, t, t, t - 101, 1'b0, 16'sh0000, 1'b0, 16'sh0000));
        // fall then fault in one step
        send_req(set_req(MODE_BALANCING));
        send_req(step_req(t, t - 501, t, t, 1'b0, 16'sh0000, 1'b0, 16'sh0000));
        // fallen, interrupt silence forces fault without a dump
        send_req(set_req(MODE_FALLEN));
        send_req(step_req(t, t, t - 501, t, 1'b0, 16'sh0000, 1'b0, 16'sh0000));
        send_req(set_req(MODE_FAULT));
        send_req(step_req(t, 32'd1, 32'd1, 32'd1, 1'b1, 16'sh7fff, 1'b1, 16'sh7fff));
        // disarmed ignores stale links
        send_req(set_req(MODE_DISARMED));
        send_req(step_req(t, 32'd1, 32'd1, 32'd1, 1'b1, 16'sh7fff, 1'b1, 16'sh7fff));
        // wrapped ages and never-seen links
        send_req(set_req(MODE_BALANCING));
        send_req(step_req(32'd5, 32'hffff_fff0, 32'd0, 32'd0, 1'b0, 16'sh0000, 1'b0,
                          16'sh0000));
        send_req(step_req(32'hffff_ffff, 32'd0, 32'd0, 32'd0, 1'b0, 16'sh0000, 1'b0,
                          16'sh0000));
        send_req(step_req(32'd0, 32'd1, 32'd0, 32'd0, 1'b0, 16'sh0000, 1'b0, 16'sh0000));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        sent      = 0;
        settings_used = 1;
        active_cfg.imu_fallen_ms   = IMU_FALLEN_RST;
        active_cfg.imu_fatal_ms    = IMU_FATAL_RST;
        active_cfg.motor_fallen_ms = MOTOR_FALLEN_RST;
        active_cfg.motor_fatal_ms  = MOTOR_FATAL_RST;
        active_cfg.tilt_kill       = TILT_KILL_RST;
        active_cfg.dump_secs       = DUMP_SECS_RST;
        clock_ms = $urandom();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // random phases, each under its own register settings
        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
                load_settings(phase_settings(p));
            steady <= (p == 3);
            repeat (140)
            begin
                if ($urandom_range(199) == 0)
                    drain();
                send_req(random_req());
            end
        end

        drain();
        repeat (10) @(negedge clk);

        $display("ran %0d requests under %0d register settings, %0d results checked",
                 sent, settings_used, results_checked);
        $display("%0d falls raised a dump request, %0d mismatches", dumps_seen, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/bms_pkg.sv
src/bms_monitor.sv
src/bms_mode.sv
src/balance_mode_supervisor_top.sv
test/bms_mode_checker.sv
test/balance_mode_supervisor_top_tb.sv
